[rtl/touch_gesture_classifier_core_defines.svh]
// Assertion macros shared by the checker files of the gesture classifier.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gesture classifier check failed");

// Consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gesture classifier check failed");

`endif

[rtl/tgc_pkg.sv]
package tgc_pkg;

    localparam int unsigned TGC_QUEUE_DEPTH = 4;
    localparam int unsigned EVT_W = 6;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_DTAP_WINDOW = 3'd0;
    localparam logic [2:0] CFG_TAP_MAX     = 3'd1;
    localparam logic [2:0] CFG_PULSE_PER   = 3'd2;
    localparam logic [2:0] CFG_PULSE_START = 3'd3;
    localparam logic [2:0] CFG_PULSE_END   = 3'd4;
    localparam logic [2:0] CFG_DEEP        = 3'd5;
    localparam logic [2:0] CFG_CARESS      = 3'd6;

    // Register values after reset.
    localparam logic [15:0] RST_DTAP_WINDOW = 16'd800;
    localparam logic [15:0] RST_TAP_MAX     = 16'd700;
    localparam logic [15:0] RST_PULSE_PER   = 16'd1000;
    localparam logic [15:0] RST_PULSE_START = 16'd3000;
    localparam logic [15:0] RST_PULSE_END   = 16'd8000;
    localparam logic [15:0] RST_DEEP        = 16'd8000;
    localparam logic [15:0] RST_CARESS      = 16'd15000;

    // Gesture codes.
    localparam logic [2:0] GEST_TAP       = 3'd0;
    localparam logic [2:0] GEST_DOUBLE    = 3'd1;
    localparam logic [2:0] GEST_SUSTAINED = 3'd2;
    localparam logic [2:0] GEST_PULSE     = 3'd3;
    localparam logic [2:0] GEST_DEEP      = 3'd4;
    localparam logic [2:0] GEST_CARESS    = 3'd5;

    // Events raised by one tick; bit position equals the gesture code, so the
    // lowest set bit is always the next event to deliver.
    typedef struct packed {
        logic caress;
        logic deep;
        logic pulse;
        logic sus;
        logic dbl;
        logic tap;
    } t_tick_rec;

    typedef struct packed {
        logic      valid;
        t_tick_rec rec;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/tgc_front.sv]
module tgc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [15:0]      i_elapsed_ms,
    input  logic             i_tap_seen,
    input  logic             i_sustained_seen,
    input  logic             i_pressed,
    input  logic [31:0]      i_press_duration_ms,
    input  tgc_pkg::t_q_stat i_q_stat,
    output tgc_pkg::t_push   o_push
);
    import tgc_pkg::*;

    logic [15:0] r_dtap_window, r_tap_max, r_pulse_per, r_pulse_start;
    logic [15:0] r_pulse_end, r_deep, r_caress;

    logic        r_held, n_held;
    logic [16:0] r_ctime, n_ctime;
    logic        r_wopen, n_wopen;
    logic [15:0] r_wleft, n_wleft;
    logic        r_hold, n_hold;
    logic        r_deep_done, n_deep_done;
    logic        r_caress_done, n_caress_done;
    logic [15:0] r_pleft, n_pleft;

    t_tick_rec   rec;
    logic        accept;
    logic        four_before;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_held        = r_held;
        n_ctime       = r_ctime;
        n_wopen       = r_wopen;
        n_wleft       = r_wleft;
        n_hold        = r_hold;
        n_deep_done   = r_deep_done;
        n_caress_done = r_caress_done;
        n_pleft       = r_pleft;
        rec           = '0;
        four_before   = 1'b0;

        // Tap handling: a tap inside an open window is a double tap.
        if (i_tap_seen) begin
            if (n_wopen) begin
                n_held  = 1'b0;
                n_ctime = '0;
                n_wopen = 1'b0;
                n_wleft = '0;
                rec.dbl = 1'b1;
            end else if (!n_held) begin
                n_held  = 1'b1;
                n_ctime = '0;
            end
        end

        // Timing of the candidate press.
        if (n_held) begin
            if (!i_pressed) begin
                if (n_ctime <= {1'b0, r_tap_max}) begin
                    n_wopen = 1'b1;
                    n_wleft = r_dtap_window;
                end
                n_held  = 1'b0;
                n_ctime = '0;
            end else if (n_ctime <= {1'b0, r_tap_max}) begin
                n_ctime = n_ctime + {1'b0, i_elapsed_ms};
            end else begin
                n_held  = 1'b0;
                n_ctime = '0;
            end
        end

        // Window expiry gives a single tap.
        if (n_wopen) begin
            if (n_wleft <= i_elapsed_ms) begin
                n_wopen = 1'b0;
                n_wleft = '0;
                rec.tap = 1'b1;
            end else begin
                n_wleft = n_wleft - i_elapsed_ms;
            end
        end

        if (i_sustained_seen) begin
            n_hold        = 1'b1;
            n_deep_done   = 1'b0;
            n_caress_done = 1'b0;
            n_pleft       = r_pulse_per;
            rec.sus       = 1'b1;
        end

        if (n_hold) begin
            if (!i_pressed) begin
                n_hold        = 1'b0;
                n_deep_done   = 1'b0;
                n_caress_done = 1'b0;
            end else begin
                if (i_press_duration_ms >= {16'd0, r_pulse_start} &&
                    i_press_duration_ms < {16'd0, r_pulse_end}) begin
                    if (n_pleft <= i_elapsed_ms) begin
                        n_pleft   = r_pulse_per;
                        rec.pulse = 1'b1;
                    end else begin
                        n_pleft = n_pleft - i_elapsed_ms;
                    end
                end
                if (!n_deep_done && i_press_duration_ms >= {16'd0, r_deep}) begin
                    n_deep_done = 1'b1;
                    rec.deep    = 1'b1;
                end
                // Only four events fit in one tick; caress then waits a tick.
                four_before = (rec.tap || rec.dbl) && rec.sus && rec.pulse && rec.deep;
                if (!n_caress_done && i_press_duration_ms >= {16'd0, r_caress} &&
                    !four_before) begin
                    n_caress_done = 1'b1;
                    rec.caress    = 1'b1;
                end
            end
        end
    end

    assign o_push.valid = accept && (rec != '0);
    assign o_push.rec   = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_ctime       <= '0;
            r_wopen       <= 1'b0;
            r_wleft       <= '0;
            r_hold        <= 1'b0;
            r_deep_done   <= 1'b0;
            r_caress_done <= 1'b0;
            r_pleft       <= '0;
        end else if (accept) begin
            r_held        <= n_held;
            r_ctime       <= n_ctime;
            r_wopen       <= n_wopen;
            r_wleft       <= n_wleft;
            r_hold        <= n_hold;
            r_deep_done   <= n_deep_done;
            r_caress_done <= n_caress_done;
            r_pleft       <= n_pleft;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtap_window <= RST_DTAP_WINDOW;
            r_tap_max     <= RST_TAP_MAX;
            r_pulse_per   <= RST_PULSE_PER;
            r_pulse_start <= RST_PULSE_START;
            r_pulse_end   <= RST_PULSE_END;
            r_deep        <= RST_DEEP;
            r_caress      <= RST_CARESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DTAP_WINDOW: r_dtap_window <= i_cfg_data;
                CFG_TAP_MAX:     r_tap_max     <= i_cfg_data;
                CFG_PULSE_PER:   r_pulse_per   <= i_cfg_data;
                CFG_PULSE_START: r_pulse_start <= i_cfg_data;
                CFG_PULSE_END:   r_pulse_end   <= i_cfg_data;
                CFG_DEEP:        r_deep        <= i_cfg_data;
                CFG_CARESS:      r_caress      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/tgc_queue.sv]
module tgc_queue #(
    parameter int unsigned DEPTH = tgc_pkg::TGC_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tgc_pkg::t_push     i_push,
    input  logic               i_pop,
    output tgc_pkg::t_tick_rec o_head,
    output tgc_pkg::t_q_stat   o_stat
);
    import tgc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_tick_rec        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push.valid) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/tgc_back.sv]
module tgc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tgc_pkg::t_tick_rec i_head,
    input  tgc_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_gesture,
    output logic               o_last_of_tick
);
    import tgc_pkg::*;

    logic [EVT_W-1:0] r_work;
    logic             r_valid;
    logic [2:0]       r_gesture;
    logic             r_last;

    logic [EVT_W-1:0] src;
    logic [EVT_W-1:0] rest;
    logic [2:0]       idx;
    logic             have;
    logic             slot;
    logic             adv;

    assign src  = (r_work != '0) ? r_work : i_head;
    assign have = (r_work != '0) || !i_q_stat.empty;
    assign slot = !r_valid || !i_stall;
    assign adv  = slot && have;
    assign rest = src & (src - EVT_W'(1));

    always_comb begin
        idx = GEST_TAP;
        for (int i = EVT_W - 1; i >= 0; i--) begin
            if (src[i]) begin
                idx = 3'(i);
            end
        end
    end

    assign o_pop          = adv && (r_work == '0);
    assign o_valid        = r_valid;
    assign o_gesture      = r_gesture;
    assign o_last_of_tick = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_work  <= '0;
        end else if (adv) begin
            r_valid <= 1'b1;
            r_work  <= rest;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gesture <= idx;
            r_last    <= (rest == '0);
        end
    end

endmodule

[rtl/touch_gesture_classifier_core.sv]
// An accepted tick is written into the event queue; its first gesture is then registered
// into the output register, where it transfers once the output is not stalled.
// Throughput: one tick per cycle enters the event queue while it is not full; gestures
// leave one per cycle unless the output stalls; a tick raises zero to four events.
// The output register and the event queue set this rate; a full queue stalls input.
// Reset is synchronous and active low: timing state, queue and output clear, and
// the seven configuration registers return to their default values.
module touch_gesture_classifier_core #(
    parameter int unsigned QUEUE_DEPTH = tgc_pkg::TGC_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port, 16-bit registers indexed in order.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Tick input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_tap_seen,
    input  logic        i_sustained_seen,
    input  logic        i_pressed,
    input  logic [31:0] i_press_duration_ms,
    // Gesture output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_gesture,
    output logic        o_last_of_tick
);
    import tgc_pkg::*;

    // The front end holds all gesture timing state and the configuration.
    // Each accepted tick is classified combinationally into a set of raised
    // events, one bit per gesture code. Ticks that raise nothing leave no
    // trace beyond the state update.
    t_push     push;
    t_q_stat   q_stat;
    t_tick_rec head;
    logic      pop;

    tgc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_elapsed_ms       (i_elapsed_ms),
        .i_tap_seen         (i_tap_seen),
        .i_sustained_seen   (i_sustained_seen),
        .i_pressed          (i_pressed),
        .i_press_duration_ms(i_press_duration_ms),
        .i_q_stat           (q_stat),
        .o_push             (push)
    );

    // The queue decouples classification from delivery, so the front end keeps
    // taking ticks while a multi-event tick drains on the output side.
    tgc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (q_stat)
    );

    // The back end peels off the lowest raised event into the output register each
    // cycle that the output is not stalled, which gives the file order since bit
    // position equals gesture code. The final event of each tick carries the last flag.
    tgc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_gesture     (o_gesture),
        .o_last_of_tick(o_last_of_tick)
    );

endmodule

[rtl/tgc_checker.sv]
`include "touch_gesture_classifier_core_defines.svh"

module tgc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_stall,
    input logic       o_valid,
    input logic [2:0] o_gesture,
    input logic       o_last_of_tick
);
    import tgc_pkg::*;

    // A stalled gesture holds.
    `TGC_ASSERT_NEXT(a_hold_stalled, o_valid && i_stall, o_valid && $stable(o_gesture) && $stable(o_last_of_tick))

    // Only defined gesture codes are delivered.
    `TGC_ASSERT_NOW(a_code_range, o_valid, o_gesture <= GEST_CARESS)

    // Events of one tick follow back to back in rising code order.
    `TGC_ASSERT_NEXT(a_tick_order, o_valid && !i_stall && !o_last_of_tick, o_valid && (o_gesture > $past(o_gesture)))

    // Caress is the highest code, so it always closes its tick.
    `TGC_ASSERT_NOW(a_caress_last, o_valid && (o_gesture == GEST_CARESS), o_last_of_tick)

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

// Self-checking testbench for the touch gesture classifier.
//
// Every tick that the block accepts is also run through a behavioral model
// kept in this file. The model appends the gestures that the tick should
// raise to a queue. A separate process checks each gesture transfer on the
// output against the oldest entry in that queue, field by field.
//
// The run has these parts, in order:
//   - directed taps: tap, double tap, dropped long press, and a repeated tap
//     during one contact;
//   - directed holds: the sustained progression with extreme durations;
//   - special cases: zero pulse period, all five events due in one tick,
//     and a write to an unused register index;
//   - random traffic in four pacing phases, each with its own register set
//     (defaults, random, all ones, all zeros);
//   - a long output hold-off while ticks keep coming, to fill the block.
module testbench;
    import tgc_pkg::*;

    localparam int          CYCLE_LIMIT         = 600000;
    localparam int          SETTLE_CYCLES       = 16;
    localparam int          MAX_EVENTS_PER_TICK = 4;
    localparam int          MAX_SEND_GAP        = 60;
    localparam int          LONG_HOLD_OFF       = 400;
    localparam int          RANDOM_PHASE_TICKS  = 80;
    localparam logic [2:0]  CFG_NO_REG          = 3'd7;

    // One input tick as the block sees it.
    typedef struct packed {
        logic [15:0] elapsed;
        logic        tap;
        logic        sus;
        logic        pressed;
        logic [31:0] duration;
    } t_tick;

    // One gesture transfer as it should leave the block.
    typedef struct packed {
        logic [2:0] gesture;
        logic       last_of_tick;
    } t_gesture_rec;

    // The seven 16-bit registers, indexed by the package's register codes.
    typedef logic [6:0][15:0] t_reg_set;

    // Clock and block ports. Every input starts at a known value.
    logic        i_clk               = 1'b0;
    logic        i_rst_n             = 1'b0;
    logic        i_cfg_we            = 1'b0;
    logic [2:0]  i_cfg_idx           = CFG_DTAP_WINDOW;
    logic [15:0] i_cfg_data          = '0;
    logic        i_valid             = 1'b0;
    logic        o_stall;
    logic [15:0] i_elapsed_ms        = '0;
    logic        i_tap_seen          = 1'b0;
    logic        i_sustained_seen    = 1'b0;
    logic        i_pressed           = 1'b0;
    logic [31:0] i_press_duration_ms = '0;
    logic        o_valid;
    logic        i_stall             = 1'b0;
    logic [2:0]  o_gesture;
    logic        o_last_of_tick;

    // Pacing knobs, changed between phases by the test tasks.
    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int hold_off_request = 0;

    // Bookkeeping.
    t_gesture_rec expected_gestures[$];
    int           error_count      = 0;
    int           ticks_sent       = 0;
    int           gestures_checked = 0;
    int           gesture_seen[6];
    int unsigned  cycle_count      = 0;

    // Copy of the register file and of the classifier state.
    t_reg_set    cfg_regs;
    logic        cand_held    = 1'b0;
    logic [16:0] cand_time    = '0;
    logic        win_open     = 1'b0;
    logic [15:0] win_left     = '0;
    logic        hold_on      = 1'b0;
    logic        deep_fired   = 1'b0;
    logic        caress_fired = 1'b0;
    logic [15:0] pulse_left   = '0;

    // Events raised by the tick being classified, in delivery order.
    logic [2:0]  tick_events[MAX_EVENTS_PER_TICK];
    int          tick_event_count;

    touch_gesture_classifier_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_elapsed_ms        (i_elapsed_ms),
        .i_tap_seen          (i_tap_seen),
        .i_sustained_seen    (i_sustained_seen),
        .i_pressed           (i_pressed),
        .i_press_duration_ms (i_press_duration_ms),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_gesture           (o_gesture),
        .o_last_of_tick      (o_last_of_tick)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a correct run ends long before this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver side. A hold-off request keeps stall high for a long, counted
    // stretch; otherwise stall is drawn per cycle from the phase's rate.
    always @(posedge i_clk) begin : drive_output_stall
        int hold_left;
        if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Output check. Values sampled at the edge are the ones that the block
    // saw at that edge, since all inputs change in the NBA region.
    always @(posedge i_clk) begin : check_gestures
        t_gesture_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_gestures.size() == 0) begin
                report_mismatch($sformatf("gesture %0d with nothing pending", o_gesture));
            end else begin
                want = expected_gestures.pop_front();
                gestures_checked++;
                if (o_gesture <= GEST_CARESS) begin
                    gesture_seen[o_gesture]++;
                end
                if (o_gesture !== want.gesture) begin
                    report_mismatch($sformatf("gesture %0d, expected %0d",
                                              o_gesture, want.gesture));
                end
                if (o_last_of_tick !== want.last_of_tick) begin
                    report_mismatch($sformatf("last_of_tick %0b, expected %0b on gesture %0d",
                                              o_last_of_tick, want.last_of_tick,
                                              want.gesture));
                end
            end
        end
    end

    function automatic void raise_event(input logic [2:0] g);
        if (tick_event_count < MAX_EVENTS_PER_TICK) begin
            tick_events[tick_event_count] = g;
            tick_event_count++;
        end
    endfunction

    // Behavioral model of one tick. It updates the state copy and queues the
    // gestures the tick raises; the final one carries last_of_tick.
    function automatic void predict_gestures(input t_tick t);
        t_gesture_rec rec;
        tick_event_count = 0;

        // A tap inside an open window closes it as a double tap. Otherwise a
        // tap starts timing a candidate, unless one is already timed.
        if (t.tap) begin
            if (win_open) begin
                cand_held = 1'b0;
                cand_time = '0;
                win_open  = 1'b0;
                win_left  = '0;
                raise_event(GEST_DOUBLE);
            end else if (!cand_held) begin
                cand_held = 1'b1;
                cand_time = '0;
            end
        end

        // A short candidate that is released opens the double tap window.
        if (cand_held) begin
            if (!t.pressed) begin
                if (cand_time <= {1'b0, cfg_regs[CFG_TAP_MAX]}) begin
                    win_open = 1'b1;
                    win_left = cfg_regs[CFG_DTAP_WINDOW];
                end
                cand_held = 1'b0;
                cand_time = '0;
            end else if (cand_time <= {1'b0, cfg_regs[CFG_TAP_MAX]}) begin
                cand_time = cand_time + {1'b0, t.elapsed};
            end else begin
                cand_held = 1'b0;
                cand_time = '0;
            end
        end

        // Window expiry turns the pending press into a single tap.
        if (win_open) begin
            if (win_left <= t.elapsed) begin
                win_open = 1'b0;
                win_left = '0;
                raise_event(GEST_TAP);
            end else begin
                win_left = win_left - t.elapsed;
            end
        end

        if (t.sus) begin
            hold_on      = 1'b1;
            deep_fired   = 1'b0;
            caress_fired = 1'b0;
            pulse_left   = cfg_regs[CFG_PULSE_PER];
            raise_event(GEST_SUSTAINED);
        end

        // Sustained progression. Caress is held back, not lost, when the
        // tick has no room left for it.
        if (hold_on) begin
            if (!t.pressed) begin
                hold_on      = 1'b0;
                deep_fired   = 1'b0;
                caress_fired = 1'b0;
            end else begin
                if (t.duration >= {16'd0, cfg_regs[CFG_PULSE_START]} &&
                    t.duration < {16'd0, cfg_regs[CFG_PULSE_END]}) begin
                    if (pulse_left <= t.elapsed) begin
                        pulse_left = cfg_regs[CFG_PULSE_PER];
                        raise_event(GEST_PULSE);
                    end else begin
                        pulse_left = pulse_left - t.elapsed;
                    end
                end
                if (!deep_fired && t.duration >= {16'd0, cfg_regs[CFG_DEEP]}) begin
                    deep_fired = 1'b1;
                    raise_event(GEST_DEEP);
                end
                if (!caress_fired && t.duration >= {16'd0, cfg_regs[CFG_CARESS]} &&
                    tick_event_count < MAX_EVENTS_PER_TICK) begin
                    caress_fired = 1'b1;
                    raise_event(GEST_CARESS);
                end
            end
        end

        for (int k = 0; k < tick_event_count; k++) begin
            rec.gesture      = tick_events[k];
            rec.last_of_tick = (k == tick_event_count - 1);
            expected_gestures.push_back(rec);
        end
    endfunction

    function automatic t_tick make_tick(input logic [15:0] elapsed, input logic tap,
                                        input logic sus, input logic pressed,
                                        input logic [31:0] duration);
        t_tick t;
        t.elapsed  = elapsed;
        t.tap      = tap;
        t.sus      = sus;
        t.pressed  = pressed;
        t.duration = duration;
        return t;
    endfunction

    // Random milliseconds scaled to a register, so that thresholds are hit
    // both just before and just after.
    function automatic logic [15:0] pick_ms(input int around);
        int hi;
        hi = around + around / 2 + 1;
        if (hi > 65535) begin
            hi = 65535;
        end
        return 16'($urandom_range(0, hi));
    endfunction

    function automatic t_reg_set random_settings();
        t_reg_set regs;
        regs[CFG_DTAP_WINDOW] = 16'($urandom_range(0, 3000));
        regs[CFG_TAP_MAX]     = 16'($urandom_range(0, 2000));
        regs[CFG_PULSE_PER]   = 16'($urandom_range(0, 3000));
        regs[CFG_PULSE_START] = 16'($urandom_range(0, 10000));
        regs[CFG_PULSE_END]   = 16'($urandom_range(0, 20000));
        regs[CFG_DEEP]        = 16'($urandom_range(0, 20000));
        regs[CFG_CARESS]      = 16'($urandom_range(0, 30000));
        return regs;
    endfunction

    // Offers one tick and returns in the time step of its transfer. Valid is
    // left high, so back-to-back ticks keep it high; an idle gap or a pause
    // lowers it in the step after the transfer.
    task automatic send_tick(input t_tick t);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_elapsed_ms        <= t.elapsed;
        i_tap_seen          <= t.tap;
        i_sustained_seen    <= t.sus;
        i_pressed           <= t.pressed;
        i_press_duration_ms <= t.duration;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_gestures(t);
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every expected gesture has been
    // seen. The tail covers ticks that raise nothing but may still be inside.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_gestures.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all seven registers, optionally followed by a write to the
    // unused index, which the block must ignore. Call only when settled.
    task automatic load_settings(input t_reg_set regs, input bit poke_unused);
        for (int r = CFG_DTAP_WINDOW; r <= CFG_CARESS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(r);
            i_cfg_data <= regs[r];
            @(posedge i_clk);
            cfg_regs[r] = regs[r];
        end
        if (poke_unused) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_NO_REG;
            i_cfg_data <= 16'hFFFF;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Default registers: a tap with a repeated tap during the same contact,
    // a double tap, and a press held past the tap limit.
    task automatic test_tap_gestures();
        send_tick(make_tick(16'd5, 1'b1, 1'b0, 1'b1, 32'd0));
        send_tick(make_tick(16'd300, 1'b1, 1'b0, 1'b1, 32'd300));
        send_tick(make_tick(16'd100, 1'b0, 1'b0, 1'b0, 32'd0));
        send_tick(make_tick(16'd700, 1'b0, 1'b0, 1'b0, 32'd0));
        send_tick(make_tick(16'd0, 1'b1, 1'b0, 1'b1, 32'd0));
        send_tick(make_tick(16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        send_tick(make_tick(16'd10, 1'b1, 1'b0, 1'b0, 32'd0));
        send_tick(make_tick(16'd400, 1'b1, 1'b0, 1'b1, 32'd0));
        send_tick(make_tick(16'd400, 1'b0, 1'b0, 1'b1, 32'd400));
        send_tick(make_tick(16'd1, 1'b0, 1'b0, 1'b1, 32'd800));
        send_tick(make_tick(16'hFFFF, 1'b0, 1'b0, 1'b0, 32'd0));
    endtask

    // Default registers: sustained touch through pulse, deep and caress, with
    // the largest elapsed time and duration.
    task automatic test_hold_gestures();
        send_tick(make_tick(16'd0, 1'b0, 1'b1, 1'b1, 32'd0));
        send_tick(make_tick(16'd500, 1'b0, 1'b0, 1'b1, 32'd2999));
        send_tick(make_tick(16'd999, 1'b0, 1'b0, 1'b1, 32'd3000));
        send_tick(make_tick(16'd1, 1'b0, 1'b0, 1'b1, 32'd7999));
        send_tick(make_tick(16'hFFFF, 1'b0, 1'b0, 1'b1, 32'd8000));
        send_tick(make_tick(16'hFFFF, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_tick(make_tick(16'd20, 1'b0, 1'b0, 1'b0, 32'd0));
    endtask

    // Zero pulse period and bounds that let all five events fall due in one
    // tick; caress must then wait for the following tick. The unused
    // register index is written with all ones on the way in.
    task automatic test_special_cases();
        t_reg_set regs;
        regs                  = cfg_regs;
        regs[CFG_PULSE_PER]   = 16'd0;
        regs[CFG_PULSE_START] = 16'd0;
        regs[CFG_PULSE_END]   = 16'hFFFF;
        regs[CFG_DEEP]        = 16'd0;
        regs[CFG_CARESS]      = 16'd0;
        settle_block();
        load_settings(regs, 1'b1);
        send_tick(make_tick(16'd0, 1'b1, 1'b0, 1'b1, 32'd0));
        send_tick(make_tick(16'd0, 1'b0, 1'b0, 1'b0, 32'd0));
        send_tick(make_tick(16'd0, 1'b1, 1'b1, 1'b1, 32'd100));
        send_tick(make_tick(16'd0, 1'b0, 1'b0, 1'b1, 32'd100));
        send_tick(make_tick(16'd7, 1'b0, 1'b0, 1'b1, 32'd100));
        send_tick(make_tick(16'd3, 1'b0, 1'b0, 1'b0, 32'd0));
    endtask

    // Mostly well-formed tap and hold sequences with random content, plus
    // some fully random ticks that break them up.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input t_reg_set regs);
        int          target;
        int          kind;
        int          steps;
        int          span;
        logic [31:0] dur;
        settle_block();
        load_settings(regs, 1'b0);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target         = ticks_sent + RANDOM_PHASE_TICKS;
        while (ticks_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                // Press, optional contact ticks, release, then a second tap
                // or a wait for the window to run out.
                send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_TAP_MAX]) / 4), 1'b1,
                                    $urandom_range(9) == 0, 1'b1, $urandom));
                steps = $urandom_range(3);
                repeat (steps) begin
                    send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_TAP_MAX]) / 2),
                                        $urandom_range(3) == 0, 1'b0, 1'b1, $urandom));
                end
                send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_TAP_MAX]) / 4), 1'b0, 1'b0,
                                    1'b0, $urandom));
                if ($urandom_range(1) == 1) begin
                    send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_DTAP_WINDOW])), 1'b1, 1'b0,
                                        1'($urandom_range(1)), $urandom));
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_DTAP_WINDOW]) / 2),
                                            1'b0, 1'b0, 1'b0, $urandom));
                    end
                end
            end else if (kind < 70) begin
                // Sustained touch with a growing duration that walks across
                // the pulse, deep and caress thresholds, then a release.
                span = int'(cfg_regs[CFG_CARESS]);
                if (int'(cfg_regs[CFG_DEEP]) > span) begin
                    span = int'(cfg_regs[CFG_DEEP]);
                end
                if (int'(cfg_regs[CFG_PULSE_END]) > span) begin
                    span = int'(cfg_regs[CFG_PULSE_END]);
                end
                dur = $urandom_range(0, 100);
                send_tick(make_tick(pick_ms(100), $urandom_range(4) == 0, 1'b1, 1'b1, dur));
                steps = $urandom_range(3, 8);
                repeat (steps) begin
                    dur = dur + $urandom_range(0, span / 3 + 1);
                    send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_PULSE_PER])),
                                        $urandom_range(9) == 0,
                                        $urandom_range(15) == 0, 1'b1, dur));
                end
                if ($urandom_range(7) == 0) begin
                    send_tick(make_tick(pick_ms(int'(cfg_regs[CFG_PULSE_PER])), 1'b0, 1'b0,
                                        1'b1, 32'hFFFF_FFFF - $urandom_range(0, 3)));
                end
                send_tick(make_tick(pick_ms(100), 1'b0, 1'b0, 1'b0, 32'd0));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_tick(make_tick(16'($urandom_range(0, 65535)),
                                        1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)), $urandom));
                end
            end
        end
    endtask

    // Output held off for a long counted stretch while ticks keep coming,
    // each raising several gestures, so the block fills and stalls its input.
    task automatic test_backpressure();
        t_reg_set regs;
        regs                  = cfg_regs;
        regs[CFG_PULSE_PER]   = 16'd0;
        regs[CFG_PULSE_START] = 16'd0;
        regs[CFG_PULSE_END]   = 16'hFFFF;
        settle_block();
        load_settings(regs, 1'b0);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = LONG_HOLD_OFF;
        repeat (24) begin
            send_tick(make_tick(pick_ms(2000), 1'($urandom_range(1)), 1'b1, 1'b1,
                                $urandom_range(0, 60000)));
        end
    endtask

    initial begin
        t_reg_set default_regs;
        t_reg_set zero_regs;
        t_reg_set ones_regs;

        default_regs[CFG_DTAP_WINDOW] = RST_DTAP_WINDOW;
        default_regs[CFG_TAP_MAX]     = RST_TAP_MAX;
        default_regs[CFG_PULSE_PER]   = RST_PULSE_PER;
        default_regs[CFG_PULSE_START] = RST_PULSE_START;
        default_regs[CFG_PULSE_END]   = RST_PULSE_END;
        default_regs[CFG_DEEP]        = RST_DEEP;
        default_regs[CFG_CARESS]      = RST_CARESS;
        zero_regs                     = '0;
        ones_regs                     = '1;
        cfg_regs                      = default_regs;
        foreach (gesture_seen[g]) begin
            gesture_seen[g] = 0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tap_gestures();
        test_hold_gestures();
        test_special_cases();
        test_random_traffic(0, 0, default_regs);
        test_random_traffic(83, 0, random_settings());
        test_random_traffic(0, 83, ones_regs);
        test_random_traffic(13, 13, zero_regs);
        test_backpressure();
        settle_block();

        $display("summary: %0d ticks, %0d gestures checked (tap %0d, double %0d, sustained %0d,",
                 ticks_sent, gestures_checked, gesture_seen[GEST_TAP],
                 gesture_seen[GEST_DOUBLE], gesture_seen[GEST_SUSTAINED]);
        $display("summary: pulse %0d, deep %0d, caress %0d), four pacing phases, long hold-off",
                 gesture_seen[GEST_PULSE], gesture_seen[GEST_DEEP], gesture_seen[GEST_CARESS]);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
